// ===== rtl/mshw_pkg.sv =====
// ----------------------------------------------------------------------------
// mshw_pkg
// Shared types and constants for the multi-sender heartbeat watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package mshw_pkg;

  localparam int NUM_SENDERS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  localparam logic [31:0] EXPIRE_RESET = 32'd1000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BEAT  = 2'd1,
    OP_CHECK = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_RESP,
    S_SW_RD,
    S_SW_EVAL,
    S_EM_RD,
    S_EM_OUT,
    S_CLOSE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/multi_sender_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_sender_heartbeat_watchdog
// Sender table with beat times and suspect/dead marks, swept by a sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Add, beat and query
// give one result each, through the S_RD and S_RESP states. A check sweep
// walks the table twice, a read state and an evaluate or output state per
// entry each time, through the single read port of the beat-time memory and
// one shared subtract-and-compare unit, then closes. Results show for one
// cycle with result_valid high and cannot be held off.
`default_nettype none

module multi_sender_heartbeat_watchdog #(
  parameter int NUM_SENDERS = mshw_pkg::NUM_SENDERS_DEF,
  parameter int TIME_BITS   = mshw_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [31:0]          cfg_wr_data,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           opcode,
  input  wire logic [3:0]           sender_index,
  input  wire logic [TIME_BITS-1:0] time_value,
  output logic                      result_valid,
  output logic [3:0]                out_sender,
  output logic                      newly_dead,
  output logic [TIME_BITS-1:0]      last_beat_time,
  output logic                      is_present,
  output logic                      is_suspect,
  output logic                      is_dead,
  output logic [4:0]                dead_count,
  output logic                      last_result
);

  localparam int IDX_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int DC_W  = $clog2(NUM_SENDERS + 1);
  localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(NUM_SENDERS - 1);

  mshw_pkg::state_t state, state_next;

  logic [31:0]            expire_interval;
  mshw_pkg::op_t          op_q;
  logic [3:0]             idx_q;
  logic                   in_table_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [IDX_W-1:0]       ptr;
  logic [NUM_SENDERS-1:0] present;
  logic [NUM_SENDERS-1:0] suspect;
  logic [NUM_SENDERS-1:0] dead;
  logic [NUM_SENDERS-1:0] newly;
  logic [DC_W-1:0]        dcount;

  logic [TIME_BITS-1:0]   mem [NUM_SENDERS];
  logic [TIME_BITS-1:0]   rd_data;

  logic                   accept;
  logic                   ptr_last;
  logic [TIME_BITS:0]     diff;
  logic                   expired;
  logic                   mem_we;
  logic [TIME_BITS-1:0]   mem_wdata;
  logic                   res_load;
  logic [3:0]             res_sender;
  logic                   res_newly;
  logic [TIME_BITS-1:0]   res_time;
  logic                   res_present;
  logic                   res_suspect;
  logic                   res_dead;
  logic                   res_last;

  assign accept   = start && !busy;
  assign ptr_last = (ptr == LAST_PTR);

  // shared subtract and compare unit
  assign diff    = {1'b0, time_q} - {1'b0, rd_data};
  assign expired = !diff[TIME_BITS] && (diff[TIME_BITS-1:0] > TIME_BITS'(expire_interval));

  always_comb begin
    state_next = state;
    unique case (state)
      mshw_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (mshw_pkg::op_t'(opcode) == mshw_pkg::OP_CHECK) ?
                       mshw_pkg::S_SW_RD : mshw_pkg::S_RD;
        end
      end
      mshw_pkg::S_RD:      state_next = mshw_pkg::S_RESP;
      mshw_pkg::S_RESP:    state_next = mshw_pkg::S_IDLE;
      mshw_pkg::S_SW_RD:   state_next = mshw_pkg::S_SW_EVAL;
      mshw_pkg::S_SW_EVAL: state_next = ptr_last ? mshw_pkg::S_EM_RD : mshw_pkg::S_SW_RD;
      mshw_pkg::S_EM_RD:   state_next = mshw_pkg::S_EM_OUT;
      mshw_pkg::S_EM_OUT:  state_next = ptr_last ? mshw_pkg::S_CLOSE : mshw_pkg::S_EM_RD;
      mshw_pkg::S_CLOSE:   state_next = mshw_pkg::S_IDLE;
      default:             state_next = mshw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != mshw_pkg::S_IDLE);
    mem_we      = 1'b0;
    mem_wdata   = '0;
    res_load    = 1'b0;
    res_sender  = '0;
    res_newly   = 1'b0;
    res_time    = '0;
    res_present = 1'b0;
    res_suspect = 1'b0;
    res_dead    = 1'b0;
    res_last    = 1'b0;
    unique case (state)
      mshw_pkg::S_RESP: begin
        res_load   = 1'b1;
        res_sender = idx_q;
        res_last   = 1'b1;
        if (in_table_q) begin
          res_suspect = suspect[ptr];
          res_dead    = dead[ptr];
          unique case (op_q)
            mshw_pkg::OP_BEAT: begin
              mem_we      = 1'b1;
              mem_wdata   = time_q;
              res_time    = time_q;
              res_present = 1'b1;
            end
            mshw_pkg::OP_ADD: begin
              mem_we      = !present[ptr];
              res_time    = present[ptr] ? rd_data : '0;
              res_present = 1'b1;
            end
            default: begin
              res_time    = present[ptr] ? rd_data : '0;
              res_present = present[ptr];
            end
          endcase
        end
      end
      mshw_pkg::S_EM_OUT: begin
        res_load    = newly[ptr];
        res_sender  = 4'(ptr);
        res_newly   = 1'b1;
        res_time    = rd_data;
        res_present = present[ptr];
        res_suspect = suspect[ptr];
        res_dead    = dead[ptr];
      end
      mshw_pkg::S_CLOSE: begin
        res_load = 1'b1;
        res_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mshw_pkg::S_IDLE;
      expire_interval <= mshw_pkg::EXPIRE_RESET;
      present         <= '0;
      suspect         <= '0;
      dead            <= '0;
      newly           <= '0;
      dcount          <= '0;
      result_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_load;
      if (cfg_wr_en) begin
        expire_interval <= cfg_wr_data;
      end
      if (accept) begin
        newly <= '0;
      end
      if (state == mshw_pkg::S_RESP && in_table_q && op_q != mshw_pkg::OP_QUERY) begin
        present[ptr] <= 1'b1;
      end
      if (state == mshw_pkg::S_SW_EVAL && present[ptr]) begin
        if (expired && !suspect[ptr]) begin
          suspect[ptr] <= 1'b1;
        end else if (expired && !dead[ptr]) begin
          dead[ptr]  <= 1'b1;
          newly[ptr] <= 1'b1;
          dcount     <= dcount + 1'b1;
        end else if (!expired && dead[ptr]) begin
          suspect[ptr] <= 1'b0;
          dead[ptr]    <= 1'b0;
          dcount       <= dcount - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= mshw_pkg::op_t'(opcode);
      idx_q      <= sender_index;
      in_table_q <= (32'(sender_index) < NUM_SENDERS);
      time_q     <= time_value;
      ptr        <= (mshw_pkg::op_t'(opcode) == mshw_pkg::OP_CHECK) ?
                    '0 : IDX_W'(sender_index);
    end else if ((state == mshw_pkg::S_SW_EVAL || state == mshw_pkg::S_EM_OUT)) begin
      ptr <= ptr_last ? '0 : ptr + 1'b1;
    end
    if (mem_we) begin
      mem[ptr] <= mem_wdata;
    end
    rd_data <= mem[ptr];
    if (res_load) begin
      out_sender     <= res_sender;
      newly_dead     <= res_newly;
      last_beat_time <= res_time;
      is_present     <= res_present;
      is_suspect     <= res_suspect;
      is_dead        <= res_dead;
      dead_count     <= 5'(dcount);
      last_result    <= res_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mshw_checker.sv =====
// ----------------------------------------------------------------------------
// mshw_checker
// Port-level checks for the heartbeat watchdog, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mshw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid,
  input wire logic newly_dead,
  input wire logic is_present,
  input wire logic is_suspect,
  input wire logic is_dead,
  input wire logic last_result
);

  // no word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word right after reset");

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // more words follow a non-final word
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> busy)
    else $error("idle before final word");

  // a newly dead report carries all marks and is never the final word
  a_newly_marks: assert property (@(posedge clk) disable iff (rst)
    (result_valid && newly_dead) |->
      (is_present && is_suspect && is_dead && !last_result))
    else $error("bad newly dead word");

endmodule

bind multi_sender_heartbeat_watchdog mshw_checker u_mshw_checker (.*);

`default_nettype wire
